// ===== sv/stop_and_wait_segment_sender_defines.svh =====
// ----------------------------------------------------------------------------
// Stop-and-wait segment sender assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_SEGMENT_SENDER_DEFINES_SVH
`define STOP_AND_WAIT_SEGMENT_SENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWS_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sws assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sws assertion failed");

`endif

// ===== sv/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// Stop-and-wait segment sender package
// Event, action, phase and configuration types shared by the block.
// ----------------------------------------------------------------------------
package sws_pkg;

    typedef enum logic [2:0] {
        REQ_START    = 3'd0,
        REQ_TX_DONE  = 3'd1,
        REQ_ACK      = 3'd2,
        REQ_RX_FAIL  = 3'd3,
        REQ_TIMEOUT  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ACT_SEND     = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_ABORT    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CAUSE_FIRST   = 2'd0,
        CAUSE_NACK    = 2'd1,
        CAUSE_TIMEOUT = 2'd2
    } cause_t;

    typedef enum logic [1:0] {
        ACK_PENDING = 2'd0,
        ACK_OK      = 2'd1,
        ACK_FAIL    = 2'd2,
        ACK_TIMEOUT = 2'd3
    } ack_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_WAIT_TX  = 3'b010,
        PH_WAIT_ACK = 3'b100
    } phase_t;

    localparam logic [7:0] CFG_LAST_SEGMENT  = 8'd0;
    localparam logic [7:0] CFG_RETRY_LIMIT   = 8'd1;
    localparam logic [7:0] CFG_ACK_OK_MASK   = 8'd2;
    localparam logic [7:0] CFG_SEGMENT_BYTES = 8'd3;

    localparam logic [15:0] LAST_MARK = 16'h8000;

    localparam logic [15:0] RST_LAST_SEGMENT  = 16'd0;
    localparam logic [7:0]  RST_RETRY_LIMIT   = 8'd3;
    localparam logic [7:0]  RST_ACK_OK_MASK   = 8'd1;
    localparam logic [7:0]  RST_SEGMENT_BYTES = 8'd64;

    typedef struct packed {
        logic [15:0] last_segment;
        logic [7:0]  retry_limit;
        logic [7:0]  ack_ok_mask;
        logic [7:0]  segment_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] ack_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] segment_number;
        logic [23:0] storage_offset;
        logic [15:0] header_word;
        logic [1:0]  send_cause;
    } result_t;

endpackage

// ===== sv/sws_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four software registers, written through the configuration port.
// ----------------------------------------------------------------------------
module sws_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [7:0]    wr_index,
    input  logic [15:0]   wr_data,
    output sws_pkg::cfg_t cfg
);
    import sws_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_LAST_SEGMENT:  cfg_next.last_segment  = wr_data;
                CFG_RETRY_LIMIT:   cfg_next.retry_limit   = wr_data[7:0];
                CFG_ACK_OK_MASK:   cfg_next.ack_ok_mask   = wr_data[7:0];
                CFG_SEGMENT_BYTES: cfg_next.segment_bytes = wr_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.last_segment  <= RST_LAST_SEGMENT;
            cfg_reg.retry_limit   <= RST_RETRY_LIMIT;
            cfg_reg.ack_ok_mask   <= RST_ACK_OK_MASK;
            cfg_reg.segment_bytes <= RST_SEGMENT_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/sws_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one event per transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module sws_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  sws_pkg::item_t item_in,
    input  logic           consume,
    output logic           valid,
    output sws_pkg::item_t item_out
);
    import sws_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (consume)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_in;
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// ===== sv/sws_core.sv =====
// ----------------------------------------------------------------------------
// Sender core
// Protocol state and the combinational step that takes one event and may produce a
// command: latching, phase moves, retry accounting and the send fields.
// ----------------------------------------------------------------------------
module sws_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  sws_pkg::item_t   item,
    input  sws_pkg::cfg_t    cfg,
    output logic             emit,
    output sws_pkg::result_t result
);
    import sws_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [7:0]  retries_reg;
    logic [7:0]  retries_next;
    ack_t        latch_reg;
    ack_t        latch_next;
    logic        txf_reg;
    logic        txf_next;

    logic        event_seen;
    logic        do_tx;
    ack_t        got;
    action_t     act;
    cause_t      cause;
    logic        is_send;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        retries_next = retries_reg;
        latch_next   = latch_reg;
        txf_next     = txf_reg;
        event_seen   = 1'b0;
        do_tx        = 1'b0;
        got          = ACK_PENDING;
        emit         = 1'b0;
        act          = ACT_SEND;
        cause        = CAUSE_FIRST;

        if (fire)
        begin
            unique case (item.req_type)
                REQ_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        count_next   = '0;
                        latch_next   = ACK_PENDING;
                        txf_next     = 1'b0;
                        retries_next = cfg.retry_limit;
                        do_tx        = 1'b1;
                    end
                end
                REQ_TX_DONE:
                begin
                    txf_next   = 1'b1;
                    event_seen = 1'b1;
                end
                REQ_ACK:
                begin
                    latch_next = ((item.ack_byte & cfg.ack_ok_mask) != 8'd0) ?
                                 ACK_OK : ACK_FAIL;
                    event_seen = 1'b1;
                end
                REQ_RX_FAIL:
                begin
                    latch_next = ACK_FAIL;
                    event_seen = 1'b1;
                end
                REQ_TIMEOUT:
                begin
                    latch_next = ACK_TIMEOUT;
                    event_seen = 1'b1;
                end
                default:
                begin
                    event_seen = 1'b0;
                end
            endcase

            // Latched events are consumed in the same step once the phase allows.
            if (event_seen)
            begin
                if (phase_next == PH_WAIT_TX && txf_next)
                begin
                    txf_next   = 1'b0;
                    phase_next = PH_WAIT_ACK;
                end
                if (phase_next == PH_WAIT_ACK && latch_next != ACK_PENDING)
                begin
                    got        = latch_next;
                    latch_next = ACK_PENDING;
                    unique case (got)
                        ACK_OK:
                        begin
                            if (count_reg == cfg.last_segment)
                            begin
                                phase_next = PH_IDLE;
                                emit       = 1'b1;
                                act        = ACT_COMPLETE;
                            end
                            else
                            begin
                                count_next   = count_reg + 16'd1;
                                retries_next = cfg.retry_limit;
                                do_tx        = 1'b1;
                            end
                        end
                        ACK_FAIL:
                        begin
                            do_tx = 1'b1;
                            cause = CAUSE_NACK;
                        end
                        ACK_TIMEOUT:
                        begin
                            do_tx = 1'b1;
                            cause = CAUSE_TIMEOUT;
                        end
                        default:
                        begin
                            do_tx = 1'b0;
                        end
                    endcase
                end
            end

            if (do_tx)
            begin
                emit = 1'b1;
                if (retries_next == 8'd0)
                begin
                    phase_next = PH_IDLE;
                    act        = ACT_ABORT;
                end
                else
                begin
                    retries_next = retries_next - 8'd1;
                    phase_next   = PH_WAIT_TX;
                    act          = ACT_SEND;
                end
            end
        end
    end

    assign is_send = (act == ACT_SEND);

    always_comb
    begin
        result.action         = act;
        result.segment_number = count_next;
        result.storage_offset = '0;
        result.header_word    = '0;
        result.send_cause     = '0;
        if (is_send)
        begin
            result.storage_offset = 24'(count_next) * 24'(cfg.segment_bytes);
            result.header_word    = (count_next == cfg.last_segment) ?
                                    (count_next ^ LAST_MARK) : count_next;
            result.send_cause     = cause;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            retries_reg <= '0;
            latch_reg   <= ACK_PENDING;
            txf_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            retries_reg <= retries_next;
            latch_reg   <= latch_next;
            txf_reg     <= txf_next;
        end
    end

endmodule

// ===== sv/sws_out_stage.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one command until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module sws_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sws_pkg::result_t result_in,
    input  logic             taken,
    output logic             valid,
    output sws_pkg::result_t result_out
);
    import sws_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (taken)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== sv/stop_and_wait_segment_sender.sv =====
// An event is captured in the input register; its command is captured in the result register.
// Throughput: one event per cycle while not stalled; the step logic is combinational
// between the input register and the result register.
// The event input stalls only while both registers are full and the command is not taken.
// Reset (rst_n, asynchronous, active low) returns the phase to idle, clears the
// counters and latches and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Stop-and-wait segment sender
// Sends image segments one at a time, resending on negative ack or timeout
// and aborting when a segment runs out of transmissions.
// ----------------------------------------------------------------------------
`include "stop_and_wait_segment_sender_defines.svh"

module stop_and_wait_segment_sender (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  ack_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [15:0] segment_number,
    output logic [23:0] storage_offset,
    output logic [15:0] header_word,
    output logic [1:0]  send_cause,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sws_pkg::*;

    cfg_t    cfg;
    item_t   item_in;
    item_t   item_held;
    logic    stage_valid;
    logic    advance;
    logic    fire;
    logic    in_fire;
    logic    emit;
    result_t step_result;
    result_t out_result;

    assign cfg_ready = 1'b1;

    assign item_in.req_type = req_type;
    assign item_in.ack_byte = ack_byte;

    // The held event moves on whenever the result register is free or draining.
    assign advance  = !out_valid || out_ready;
    assign fire     = stage_valid && advance;
    assign in_ready = !stage_valid || advance;
    assign in_fire  = in_valid && in_ready;

    sws_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sws_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .item_in  (item_in),
        .consume  (fire),
        .valid    (stage_valid),
        .item_out (item_held)
    );

    sws_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_held),
        .cfg    (cfg),
        .emit   (emit),
        .result (step_result)
    );

    sws_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .result_in  (step_result),
        .taken      (out_ready),
        .valid      (out_valid),
        .result_out (out_result)
    );

    assign action         = out_result.action;
    assign segment_number = out_result.segment_number;
    assign storage_offset = out_result.storage_offset;
    assign header_word    = out_result.header_word;
    assign send_cause     = out_result.send_cause;

    `SWS_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, !in_ready,
        stage_valid && out_valid && !out_ready)
    `SWS_ASSERT_NEXT(a_command_captured, clk, rst_n, emit, out_valid)
    `SWS_ASSERT_SAME(a_idle_fields_zero, clk, rst_n,
        out_valid && (action == ACT_COMPLETE || action == ACT_ABORT),
        storage_offset == 24'd0 && header_word == 16'd0 && send_cause == 2'd0)

endmodule
